// File: design/clbc_pkg.sv
// ----------------------------------------------------------------------------
// clbc_pkg
// shared types and codes of the column layout bounds checker
// ----------------------------------------------------------------------------
package clbc_pkg;

    localparam int ROWS_W    = 40;
    localparam int STRIDE_W  = 63;
    localparam int FIELD_W   = 64;
    localparam int WIDTH_W   = 32;
    localparam int DIGIT_W   = 8;
    localparam int NUM_CELLS = WIDTH_W / DIGIT_W;
    localparam int ACC_W     = ROWS_W + WIDTH_W;

    typedef enum logic [1:0] {
        KIND_FIXED   = 2'd0,
        KIND_BOOL    = 2'd1,
        KIND_VARLEN  = 2'd2,
        KIND_UNKNOWN = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_VALIDITY  = 4'd1,
        ST_DATA      = 4'd2,
        ST_WIDTH     = 4'd3,
        ST_FIXED_CAP = 4'd4,
        ST_BOOL      = 4'd5,
        ST_OFFSETS   = 4'd6,
        ST_VARLEN    = 4'd7,
        ST_KIND      = 4'd8
    } status_t;

    typedef enum logic {
        REG_ROWS   = 1'b0,
        REG_STRIDE = 1'b1
    } reg_index_t;

    // one descriptor word moving down the multiply chain
    typedef struct packed {
        logic                valid;
        status_t             status;
        logic                need_fixed;
        logic [STRIDE_W-1:0] dcap;
        logic [WIDTH_W-1:0]  width_rem;
        logic [ACC_W-1:0]    acc;
    } token_t;

    // overflow-safe bounds check of (offset, length) against the stride
    function automatic logic in_bounds(
        input logic signed [FIELD_W-1:0] offset,
        input logic signed [FIELD_W-1:0] length,
        input logic [STRIDE_W-1:0]       limit
    );
        logic signed [FIELD_W+1:0] o;
        logic signed [FIELD_W+1:0] l;
        logic signed [FIELD_W+1:0] m;
        o = (FIELD_W+2)'(offset);
        l = (FIELD_W+2)'(length);
        m = {3'b000, limit};
        return (o >= 0) && (l >= 0) && (o <= m) && (l <= m - o);
    endfunction

endpackage

// File: design/clbc_front.sv
// ----------------------------------------------------------------------------
// clbc_front
// bounds and kind checks of one descriptor, registered into a chain token
// ----------------------------------------------------------------------------
module clbc_front
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  clbc_pkg::kind_t                        kind,
    input  logic signed [clbc_pkg::FIELD_W-1:0]    vstart,
    input  logic signed [clbc_pkg::FIELD_W-1:0]    dstart,
    input  logic signed [clbc_pkg::FIELD_W-1:0]    dcap,
    input  logic signed [clbc_pkg::WIDTH_W-1:0]    width,
    input  logic signed [clbc_pkg::FIELD_W-1:0]    ostart,
    input  logic signed [clbc_pkg::FIELD_W-1:0]    vcap,
    input  logic [clbc_pkg::ROWS_W-1:0]            rows,
    input  logic [clbc_pkg::STRIDE_W-1:0]          stride,
    output clbc_pkg::token_t                       tok
);

    logic [clbc_pkg::ROWS_W:0]       rows_ext;
    logic signed [clbc_pkg::FIELD_W-1:0] bitmap_len;
    logic signed [clbc_pkg::FIELD_W-1:0] offsets_len;
    logic                            width_bad;
    clbc_pkg::status_t               status;
    logic                            need_fixed;
    clbc_pkg::token_t                tok_reg;
    clbc_pkg::token_t                tok_next;

    assign rows_ext    = {1'b0, rows};
    // ceil(rows/8) and (rows+1)*4, both far below the signed range
    assign bitmap_len  = clbc_pkg::FIELD_W'((rows_ext + 41'd7) >> 3);
    assign offsets_len = clbc_pkg::FIELD_W'({rows_ext + 41'd1, 2'b00});
    assign width_bad   = width[clbc_pkg::WIDTH_W-1] || (width == '0);

    always_comb
    begin
        status     = clbc_pkg::ST_OK;
        need_fixed = 1'b0;
        if (!clbc_pkg::in_bounds(vstart, bitmap_len, stride))
        begin
            status = clbc_pkg::ST_VALIDITY;
        end
        else if (!clbc_pkg::in_bounds(dstart, dcap, stride))
        begin
            status = clbc_pkg::ST_DATA;
        end
        else
        begin
            unique case (kind)
                clbc_pkg::KIND_FIXED:
                begin
                    if (width_bad)
                        status = clbc_pkg::ST_WIDTH;
                    else
                        need_fixed = 1'b1;
                end
                clbc_pkg::KIND_BOOL:
                begin
                    if (dcap < bitmap_len)
                        status = clbc_pkg::ST_BOOL;
                end
                clbc_pkg::KIND_VARLEN:
                begin
                    if (!clbc_pkg::in_bounds(ostart, offsets_len, stride))
                        status = clbc_pkg::ST_OFFSETS;
                    else if (!clbc_pkg::in_bounds(dstart, vcap, stride))
                        status = clbc_pkg::ST_VARLEN;
                end
                default:
                begin
                    status = clbc_pkg::ST_KIND;
                end
            endcase
        end
    end

    always_comb
    begin
        tok_next.valid      = accept;
        tok_next.status     = status;
        tok_next.need_fixed = need_fixed;
        tok_next.dcap       = dcap[clbc_pkg::STRIDE_W-1:0];
        tok_next.width_rem  = width;
        tok_next.acc        = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok = tok_reg;

endmodule

// File: design/clbc_cell.sv
// ----------------------------------------------------------------------------
// clbc_cell
// one multiply-accumulate cell: folds the top digit of the element width
// ----------------------------------------------------------------------------
module clbc_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [clbc_pkg::ROWS_W-1:0]   rows,
    input  clbc_pkg::token_t              tok_in,
    output clbc_pkg::token_t              tok_out
);

    localparam int PP_W = clbc_pkg::ROWS_W + clbc_pkg::DIGIT_W;

    logic [clbc_pkg::DIGIT_W-1:0] digit;
    logic [PP_W-1:0]              partial;
    clbc_pkg::token_t             tok_reg;
    clbc_pkg::token_t             tok_next;

    assign digit   = tok_in.width_rem[clbc_pkg::WIDTH_W-1 -: clbc_pkg::DIGIT_W];
    assign partial = PP_W'(rows) * PP_W'(digit);

    always_comb
    begin
        tok_next           = tok_in;
        // horner step, most significant digit first
        tok_next.acc       = (tok_in.acc << clbc_pkg::DIGIT_W)
                             + clbc_pkg::ACC_W'(partial);
        tok_next.width_rem = tok_in.width_rem << clbc_pkg::DIGIT_W;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/column_layout_bounds_checker.sv
// ----------------------------------------------------------------------------
// column_layout_bounds_checker
// checks one untrusted column descriptor per word and returns a status code
// ----------------------------------------------------------------------------
// The block takes a descriptor word in every cycle (busy is always low) and
// returns its status on status with done high for exactly one cycle;
// words come out in the order they went in and the receiver cannot
// stall. The pipeline runs through the front check stage, the
// four multiply-accumulate cells that build rows_per_batch * element_bytes
// one 8-bit digit at a time, and the final capacity compare stage.
// rows_per_batch and stride_bytes are written through cfg_we / cfg_index /
// cfg_wdata and must only change while no descriptor is in flight.
// ----------------------------------------------------------------------------
module column_layout_bounds_checker
#(
    parameter int OFFSET_WIDTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          column_kind,
    input  logic signed [63:0]                  validity_start,
    input  logic signed [63:0]                  data_start,
    input  logic signed [63:0]                  data_capacity,
    input  logic signed [31:0]                  element_bytes,
    input  logic signed [63:0]                  offsets_start,
    input  logic signed [63:0]                  varlen_capacity,
    // result side
    output logic                                done,
    output logic [3:0]                          status,
    // configuration
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [clbc_pkg::STRIDE_W-1:0]       cfg_wdata
);

    // sign-extend the low OFFSET_WIDTH bits of a descriptor field
    function automatic logic signed [63:0] narrow(input logic [63:0] f);
        logic signed [OFFSET_WIDTH-1:0] t;
        t = f[OFFSET_WIDTH-1:0];
        return 64'(t);
    endfunction

    logic [clbc_pkg::ROWS_W-1:0]   rows_reg;
    logic [clbc_pkg::STRIDE_W-1:0] stride_reg;
    logic                          accept;
    clbc_pkg::token_t              chain [0:clbc_pkg::NUM_CELLS];
    clbc_pkg::token_t              last;
    logic                          cap_short;
    clbc_pkg::status_t             status_next;
    clbc_pkg::status_t             status_reg;
    logic                          done_reg;

    // never stalls: a new word can enter in every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers, rows keeps only its low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= '0;
            stride_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (clbc_pkg::reg_index_t'(cfg_index))
                clbc_pkg::REG_ROWS:   rows_reg   <= cfg_wdata[clbc_pkg::ROWS_W-1:0];
                clbc_pkg::REG_STRIDE: stride_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front stage: validity, data and kind checks
    clbc_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .kind   (clbc_pkg::kind_t'(column_kind)),
        .vstart (narrow(validity_start)),
        .dstart (narrow(data_start)),
        .dcap   (narrow(data_capacity)),
        .width  (element_bytes),
        .ostart (narrow(offsets_start)),
        .vcap   (narrow(varlen_capacity)),
        .rows   (rows_reg),
        .stride (stride_reg),
        .tok    (chain[0])
    );

    // chain of cells building rows * element_bytes, one width digit per cell
    for (genvar i = 0; i < clbc_pkg::NUM_CELLS; i++)
    begin : g_cell
        clbc_cell u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .rows    (rows_reg),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign last = chain[clbc_pkg::NUM_CELLS];

    // with capacity >= 0 and width > 0, rows > capacity / width
    // is the same as rows * width > capacity
    assign cap_short   = last.acc > clbc_pkg::ACC_W'(last.dcap);
    assign status_next = (last.need_fixed && cap_short) ? clbc_pkg::ST_FIXED_CAP
                                                        : last.status;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign status = status_reg;

`ifndef ASSERT_OFF
    // every accepted word comes back with a done strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("result strobe missing after accepted word");

    // width and fixed capacity codes only belong to fixed width columns
    a_fixed_only: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && column_kind != clbc_pkg::KIND_FIXED) |-> ##6
        (status != clbc_pkg::ST_WIDTH && status != clbc_pkg::ST_FIXED_CAP))
        else $error("fixed width code on a non-fixed column");

    // a word that still needs the capacity compare has passed every other check
    a_need_fixed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (last.valid && last.need_fixed) |-> (last.status == clbc_pkg::ST_OK))
        else $error("capacity compare pending on a failed word");
`endif

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the column layout bounds checker
// ----------------------------------------------------------------------------
// Descriptor words go in through the start / busy command port and their
// status codes are scored against a model kept in a small scoreboard class.
// A short directed list covers each failure code, the boundaries of every
// bounds check and the field extremes. It is followed by phases of random
// words, each under its own rows / stride setting. The settings include
// zero sizes, the largest sizes and a rows write with bits above the
// register width. Most random words are built to pass the earlier checks
// so that the later checks are reached. The rest are noise or
// deliberately broken words.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int OFFSET_WIDTH  = 64;
    localparam int PHASE_WORDS   = 105;
    localparam int NUM_PHASES    = 10;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 1000;  // cycles with no handshake at all

    // one descriptor as it crosses the command port
    typedef struct {
        logic [1:0]         kind;
        logic signed [63:0] validity_start;
        logic signed [63:0] data_start;
        logic signed [63:0] data_capacity;
        logic signed [31:0] element_bytes;
        logic signed [63:0] offsets_start;
        logic signed [63:0] varlen_capacity;
    } column_word_t;

    // ------------------------------------------------------------------------
    // scoreboard: predicts the status of each accepted word and scores results
    // ------------------------------------------------------------------------
    class status_scoreboard;
        longint            rows;
        longint            stride;
        clbc_pkg::status_t expected_q[$];
        int                failures;

        function new();
            rows     = 0;
            stride   = 0;
            failures = 0;
        endfunction

        // the rows register keeps only its low bits
        function void set_reg(clbc_pkg::reg_index_t idx,
                              logic [clbc_pkg::STRIDE_W-1:0] value);
            logic [clbc_pkg::STRIDE_W-1:0] rows_mask;
            rows_mask = (63'd1 << clbc_pkg::ROWS_W) - 63'd1;
            if (idx == clbc_pkg::REG_ROWS)
                rows = longint'(value & rows_mask);
            else
                stride = longint'({1'b0, value});
        endfunction

        // 64-bit fields seen through a comparator of OFFSET_WIDTH bits
        function longint narrow(logic [63:0] u);
            logic [63:0] mask;
            if (OFFSET_WIDTH >= 64)
                return longint'(u);
            mask = (64'd1 << OFFSET_WIDTH) - 64'd1;
            if (u[OFFSET_WIDTH-1])
                return longint'(u | ~mask);
            return longint'(u & mask);
        endfunction

        // offset/length inside the stride, written so nothing can overflow
        function bit fits_in_stride(longint offset, longint length);
            if (offset < 0 || length < 0 || offset > stride)
                return 1'b0;
            return length <= stride - offset;
        endfunction

        function clbc_pkg::status_t predict_status(column_word_t w);
            longint vstart;
            longint dstart;
            longint dcap;
            longint ostart;
            longint vcap;
            longint width;
            longint map_bytes;
            vstart    = narrow(w.validity_start);
            dstart    = narrow(w.data_start);
            dcap      = narrow(w.data_capacity);
            ostart    = narrow(w.offsets_start);
            vcap      = narrow(w.varlen_capacity);
            width     = longint'(w.element_bytes);
            map_bytes = (rows + 7) / 8;
            if (!fits_in_stride(vstart, map_bytes))
                return clbc_pkg::ST_VALIDITY;
            if (!fits_in_stride(dstart, dcap))
                return clbc_pkg::ST_DATA;
            case (w.kind)
                clbc_pkg::KIND_FIXED:
                begin
                    if (width <= 0)
                        return clbc_pkg::ST_WIDTH;
                    // truncating division, dcap is non-negative here
                    if (rows > dcap / width)
                        return clbc_pkg::ST_FIXED_CAP;
                    return clbc_pkg::ST_OK;
                end
                clbc_pkg::KIND_BOOL:
                begin
                    if (dcap < map_bytes)
                        return clbc_pkg::ST_BOOL;
                    return clbc_pkg::ST_OK;
                end
                clbc_pkg::KIND_VARLEN:
                begin
                    if (!fits_in_stride(ostart, (rows + 1) * 4))
                        return clbc_pkg::ST_OFFSETS;
                    if (!fits_in_stride(dstart, vcap))
                        return clbc_pkg::ST_VARLEN;
                    return clbc_pkg::ST_OK;
                end
                default:
                    return clbc_pkg::ST_KIND;
            endcase
        endfunction

        function void note_word(column_word_t w);
            expected_q.insert(expected_q.size(), predict_status(w));
        endfunction

        function void check_result(logic [3:0] got);
            clbc_pkg::status_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: status %0d with no word pending", $time, got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want, got);
                failures++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, dut ports and instance
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                          start;
    logic                          busy;
    logic [1:0]                    column_kind;
    logic signed [63:0]            validity_start;
    logic signed [63:0]            data_start;
    logic signed [63:0]            data_capacity;
    logic signed [31:0]            element_bytes;
    logic signed [63:0]            offsets_start;
    logic signed [63:0]            varlen_capacity;
    logic                          done;
    logic [3:0]                    status;
    logic                          cfg_we;
    logic                          cfg_index;
    logic [clbc_pkg::STRIDE_W-1:0] cfg_wdata;

    status_scoreboard sb;
    int               quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    column_layout_bounds_checker #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .column_kind     (column_kind),
        .validity_start  (validity_start),
        .data_start      (data_start),
        .data_capacity   (data_capacity),
        .element_bytes   (element_bytes),
        .offsets_start   (offsets_start),
        .varlen_capacity (varlen_capacity),
        .done            (done),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // monitor and watchdog: inputs are driven by nba, so at the edge we
    // still see the values that the block samples
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        column_word_t seen;
        bit           took_word;
        if (rst_n === 1'b1)
        begin
            took_word = (start === 1'b1) && (busy === 1'b0);
            if (took_word)
            begin
                seen.kind            = column_kind;
                seen.validity_start  = validity_start;
                seen.data_start      = data_start;
                seen.data_capacity   = data_capacity;
                seen.element_bytes   = element_bytes;
                seen.offsets_start   = offsets_start;
                seen.varlen_capacity = varlen_capacity;
                sb.note_word(seen);
            end
            if (done === 1'b1)
                sb.check_result(status);
            // run is stuck if nothing moves for too long
            if (took_word || done === 1'b1)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // value in [0, hi], with extra weight on both ends
    function automatic longint pick_upto(longint hi);
        logic [63:0] span;
        int          sel;
        if (hi <= 0)
            return 0;
        sel  = $urandom_range(0, 7);
        span = hi;
        span = span + 64'd1;
        if (sel == 0)
            return 0;
        if (sel == 1)
            return hi;
        return longint'(rand64() % span);
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // mostly well-formed descriptors for the current sizes, some noise
    function automatic column_word_t make_word(longint rows, longint lim);
        column_word_t w;
        longint       map_bytes;
        longint       need;
        longint       dcap;
        longint       offsets_bytes;
        int           mode;
        int           r;
        w.kind            = 2'($urandom_range(0, 3));
        w.validity_start  = rand64();
        w.data_start      = rand64();
        w.data_capacity   = rand64();
        w.element_bytes   = $urandom;
        w.offsets_start   = rand64();
        w.varlen_capacity = rand64();
        mode = $urandom_range(0, 19);
        if (mode < 2)
            return w;    // pure noise, nearly always a validity failure

        map_bytes        = (rows + 7) / 8;
        w.validity_start = pick_upto(lim - map_bytes);
        if (mode == 2)
        begin
            // bitmap just past the end, or a negative offset
            if ($urandom_range(0, 1) == 1)
                w.validity_start = lim - map_bytes + 1;
            else
                w.validity_start = -longint'($urandom_range(1, 4));
        end

        // capacity aimed at the kind's own boundary
        dcap = pick_upto(lim);
        case (w.kind)
            clbc_pkg::KIND_FIXED:
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    w.element_bytes = $urandom;
                else if (r == 1)
                    w.element_bytes = 0;
                else
                begin
                    w.element_bytes = $urandom_range(1, 16);
                    need = rows * longint'(w.element_bytes) - 1
                           + longint'($urandom_range(0, 2));
                    dcap = (need < 0) ? 0 : need;
                end
            end
            clbc_pkg::KIND_BOOL:
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    need = map_bytes - 1 + longint'($urandom_range(0, 2));
                    dcap = (need < 0) ? 0 : need;
                end
            end
            default:
            begin
            end
        endcase
        w.data_capacity = dcap;
        w.data_start    = pick_upto(lim - dcap);
        if (mode == 3)
        begin
            r = $urandom_range(0, 2);
            if (r == 0)
                w.data_capacity = -longint'($urandom_range(1, 4));
            else if (r == 1)
                w.data_start = lim - dcap + 1;
            else
                w.data_start = 64'sh8000_0000_0000_0000;
        end

        // varlen buffers near their limits
        offsets_bytes   = (rows + 1) * 4;
        w.offsets_start = pick_upto(lim - offsets_bytes);
        r = $urandom_range(0, 7);
        if (r == 0)
            w.offsets_start = lim - offsets_bytes + 1;
        else if (r == 1)
            w.offsets_start = -longint'($urandom_range(1, 4));
        w.varlen_capacity = pick_upto(lim - w.data_start);
        r = $urandom_range(0, 7);
        if (r == 0)
            w.varlen_capacity = lim - w.data_start + 1;
        else if (r == 1)
            w.varlen_capacity = -longint'($urandom_range(1, 4));
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // drive tasks
    // ------------------------------------------------------------------------
    // present a word and hold it until the block takes it; start stays high
    task automatic send_word(column_word_t w);
        start           <= 1'b1;
        column_kind     <= w.kind;
        validity_start  <= w.validity_start;
        data_start      <= w.data_start;
        data_capacity   <= w.data_capacity;
        element_bytes   <= w.element_bytes;
        offsets_start   <= w.offsets_start;
        varlen_capacity <= w.varlen_capacity;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic send_fields(logic [1:0] kind, longint vs, longint ds, longint dc,
                               int eb, longint os, longint vc);
        column_word_t w;
        w.kind            = kind;
        w.validity_start  = vs;
        w.data_start      = ds;
        w.data_capacity   = dc;
        w.element_bytes   = eb;
        w.offsets_start   = os;
        w.varlen_capacity = vc;
        send_word(w);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending until every expected status is back, then let it settle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // both registers, one write each, block idle
    task automatic write_config(logic [clbc_pkg::STRIDE_W-1:0] rows_val,
                                logic [clbc_pkg::STRIDE_W-1:0] stride_val);
        cfg_we    <= 1'b1;
        cfg_index <= clbc_pkg::REG_ROWS;
        cfg_wdata <= rows_val;
        @(posedge clk);
        sb.set_reg(clbc_pkg::REG_ROWS, rows_val);
        cfg_index <= clbc_pkg::REG_STRIDE;
        cfg_wdata <= stride_val;
        @(posedge clk);
        sb.set_reg(clbc_pkg::REG_STRIDE, stride_val);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [clbc_pkg::STRIDE_W-1:0] rows_val;
        logic [clbc_pkg::STRIDE_W-1:0] stride_val;
        logic [clbc_pkg::STRIDE_W-1:0] rows_max;
        logic [clbc_pkg::STRIDE_W-1:0] stride_max;
        int                            g;
        bit                            burst;

        // every input known from time zero
        rst_n           = 1'b0;
        start           = 1'b0;
        column_kind     = clbc_pkg::KIND_FIXED;
        validity_start  = '0;
        data_start      = '0;
        data_capacity   = '0;
        element_bytes   = '0;
        offsets_start   = '0;
        varlen_capacity = '0;
        cfg_we          = 1'b0;
        cfg_index       = clbc_pkg::REG_ROWS;
        cfg_wdata       = '0;
        quiet_cycles    = 0;
        sb              = new();
        rows_max        = (63'd1 << clbc_pkg::ROWS_W) - 63'd1;
        stride_max      = {clbc_pkg::STRIDE_W{1'b1}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers straight out of reset: zero rows, zero stride
        repeat (10)
        begin
            send_word(make_word(sb.rows, sb.stride));
            g = gap_len();
            if (g > 0)
                hold_off(g);
        end
        drain();

        // directed words: 100 rows, 1000 byte stride
        // bitmap needs 13 bytes, offsets need 404 bytes
        write_config(63'd100, 63'd1000);
        send_fields(clbc_pkg::KIND_FIXED,   0,   0,   400, 4, 0, 0);  // exactly enough
        send_fields(clbc_pkg::KIND_FIXED,   0,   0,   399, 4, 0, 0);  // one byte short
        send_fields(clbc_pkg::KIND_FIXED,   0,   0,   400, 0, 0, 0);  // zero width
        send_fields(clbc_pkg::KIND_FIXED,   0,   0,   400, 32'sh8000_0000, 0, 0);
        send_fields(clbc_pkg::KIND_FIXED,   0,   0,   1000, 32'sh7fff_ffff, 0, 0);
        send_fields(clbc_pkg::KIND_FIXED,   64'sh8000_0000_0000_0000, 0, 0, 4, 0, 0);
        send_fields(clbc_pkg::KIND_FIXED,   987, 0,   400, 4, 0, 0);  // bitmap ends at stride
        send_fields(clbc_pkg::KIND_FIXED,   988, 0,   400, 4, 0, 0);  // bitmap one past
        send_fields(clbc_pkg::KIND_BOOL,    64'sh7fff_ffff_ffff_ffff, 0, 0, 0, 0, 0);
        send_fields(clbc_pkg::KIND_BOOL,    0,   0,   -1,  0, 0, 0);  // negative capacity
        send_fields(clbc_pkg::KIND_BOOL,    0,   64'sh8000_0000_0000_0000, 13, 0, 0, 0);
        send_fields(clbc_pkg::KIND_BOOL,    0,   500, 501, 0, 0, 0);  // data one past
        send_fields(clbc_pkg::KIND_BOOL,    0,   500, 500, 0, 0, 0);  // data ends at stride
        send_fields(clbc_pkg::KIND_BOOL,    0,   0,   64'sh7fff_ffff_ffff_ffff, 0, 0, 0);
        send_fields(clbc_pkg::KIND_BOOL,    0,   0,   12,  0, 0, 0);  // bitmap too small
        send_fields(clbc_pkg::KIND_VARLEN,  0,   0,   0,   0, 596, 1000);
        send_fields(clbc_pkg::KIND_VARLEN,  0,   0,   0,   0, 597, 0);  // offsets one past
        send_fields(clbc_pkg::KIND_VARLEN,  0,   0,   0,   0, -1,  0);
        send_fields(clbc_pkg::KIND_VARLEN,  0,   100, 0,   0, 0,   901);  // varlen one past
        send_fields(clbc_pkg::KIND_VARLEN,  0,   100, 0,   0, 0,   -1);
        send_fields(clbc_pkg::KIND_VARLEN,  0,   100, 0,   0, 64'sh7fff_ffff_ffff_ffff, 900);
        send_fields(clbc_pkg::KIND_UNKNOWN, 0,   0,   0,   0, 0,   0);
        send_fields(clbc_pkg::KIND_UNKNOWN, -1,  0,   0,   0, 0,   0);  // common check first
        drain();

        // random phases, each under its own sizes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    rows_val   = '0;
                    stride_val = '0;
                end
                1:
                begin
                    rows_val   = rows_max;
                    stride_val = stride_max;
                end
                2:
                begin
                    rows_val   = stride_max;    // bits above the rows width
                    stride_val = stride_max;
                end
                3:
                begin
                    rows_val   = 63'd1;
                    stride_val = 63'd8;
                end
                4:
                begin
                    rows_val   = 63'($urandom_range(0, 64));
                    stride_val = 63'($urandom_range(0, 2000));
                end
                6:
                begin
                    rows_val   = 63'($urandom_range(1, 1000));
                    stride_val = 63'($urandom_range(0, 50000));
                end
                7:
                begin
                    rows_val   = 63'd8;
                    stride_val = stride_max;
                end
                8:
                begin
                    rows_val   = 63'($urandom_range(0, 20));
                    stride_val = 63'($urandom_range(0, 40));
                end
                default:
                begin
                    rows_val   = 63'(rand64());
                    stride_val = 63'(rand64());
                end
            endcase
            write_config(rows_val, stride_val);
            burst = (p % 3 == 1);    // some phases run without gaps
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                send_word(make_word(sb.rows, sb.stride));
                if (i == PHASE_WORDS / 2)
                    drain();    // sender waits out every pending status
                else if (!burst)
                begin
                    g = gap_len();
                    if (g > 0)
                        hold_off(g);
                end
            end
            drain();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
